FILE: sv/fsms_pkg.sv
package fsms_pkg;

  // sizes
  localparam int MAX_QUERY         = 16;
  localparam int MAX_CANDIDATE_LEN = 256;
  localparam int LEN_LIMIT         = (MAX_CANDIDATE_LEN < 256) ? MAX_CANDIDATE_LEN : 256;
  localparam int QIDX_W            = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int POS_SAT           = 511;
  localparam int SCORE_SAT         = 2097151;
  localparam int SCORE_W           = 21;
  localparam int FRAC_W            = 16;
  localparam int DEN_W             = 17;
  localparam int QDEPTH            = 2;
  localparam int QPTR_W            = 1;
  localparam int QCNT_W            = 2;

  // configuration register indexes
  localparam logic [1:0] REG_QUERY_LOW  = 2'd0;
  localparam logic [1:0] REG_QUERY_HIGH = 2'd1;
  localparam logic [1:0] REG_QUERY_LEN  = 2'd2;

  // input transaction
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_candidate;
  } in_t;

  // result transaction
  typedef struct packed {
    logic               matched;
    logic [7:0]         window_start;
    logic [7:0]         window_end;
    logic [8:0]         candidate_length;
    logic [SCORE_W-1:0] match_score;
    logic               too_long;
  } out_t;

  // per-candidate summary passed from front to back
  typedef struct packed {
    logic       best_valid;
    logic [7:0] start;
    logic [7:0] stop;
    logic [8:0] count;
    logic [4:0] qlen;
  } summ_t;

  // queue status seen by the front
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // ascii upper case to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

FILE: sv/fuzzy_subsequence_match_scorer.sv
// Fuzzy subsequence match scorer. Candidate text enters one byte per transaction, the
// final byte of each candidate marked; the query (up to 16 characters, ASCII letters
// folded to lower case) and its length sit in configuration registers. The front takes
// one byte per cycle while the queue has room, tracking the latest window start for
// every query prefix, and on the marked byte hands a summary of the shortest, leftmost
// window to a two-entry queue. The back turns each summary into one result transaction:
// candidates with no match, an overlong text or a single-position window go straight to
// the output, the others pass one multiply of span by length, then a restoring divider
// giving one of 21 quotient bits per cycle. Bytes flow at one per cycle while candidates
// outlast their scoring; shorter ones are paced by the divider once the queue fills.
module fuzzy_subsequence_match_scorer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fsms_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fsms_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i
);

  logic [63:0] query_low_q, query_high_q;
  logic [4:0]  query_len_q;

  logic              push, pop;
  fsms_pkg::summ_t   push_data, pop_data;
  fsms_pkg::q_stat_t q_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_low_q  <= '0;
      query_high_q <= '0;
      query_len_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fsms_pkg::REG_QUERY_LOW:  query_low_q  <= cfg_data_i;
        fsms_pkg::REG_QUERY_HIGH: query_high_q <= cfg_data_i;
        fsms_pkg::REG_QUERY_LEN:  query_len_q  <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // search front
  fsms_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_ready_o    (in_ready_o),
    .query_chars_i ({query_high_q, query_low_q}),
    .query_len_i   (query_len_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // summary queue
  fsms_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // scoring back end
  fsms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/fsms_queue.sv
module fsms_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fsms_pkg::summ_t push_data_i,
  input  logic            pop_i,
  output fsms_pkg::summ_t pop_data_o,
  output fsms_pkg::q_stat_t stat_o
);

  fsms_pkg::summ_t                 mem_q [fsms_pkg::QDEPTH];
  logic [fsms_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [fsms_pkg::QCNT_W-1:0]     cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

FILE: sv/fsms_front.sv
module fsms_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fsms_pkg::in_t     in_data_i,
  output logic              in_ready_o,
  input  logic [127:0]      query_chars_i,
  input  logic [4:0]        query_len_i,
  input  fsms_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output fsms_pkg::summ_t   push_data_o
);

  localparam logic [8:0] LenLimit = 9'(fsms_pkg::LEN_LIMIT);
  localparam logic [8:0] PosSat   = 9'(fsms_pkg::POS_SAT);
  localparam logic [4:0] MaxQuery = 5'(fsms_pkg::MAX_QUERY);

  logic       accept;
  logic [8:0] count_q, count_inc;
  logic [7:0] start_q [fsms_pkg::MAX_QUERY];
  logic [fsms_pkg::MAX_QUERY-1:0] valid_q;
  logic [7:0] new_start [fsms_pkg::MAX_QUERY];
  logic [fsms_pkg::MAX_QUERY-1:0] new_valid, hit, upd;
  logic [4:0] alen;
  logic [7:0] c;
  logic       search_en;
  logic [fsms_pkg::QIDX_W-1:0] last_idx;
  logic       done;

  // stage 1 to stage 2
  logic       s1_valid_q, s1_done_q, s1_last_q;
  logic [7:0] s1_pos_q, s1_start_q;
  logic [8:0] s1_count_q;
  logic [4:0] s1_qlen_q;

  // best window
  logic       best_valid_q;
  logic [7:0] best_start_q, best_end_q;
  logic       take_new;
  logic [7:0] span, best_span;
  logic       nb_valid;
  logic [7:0] nb_start, nb_end;
  logic [fsms_pkg::QCNT_W:0] credit;

  // room for a summary must exist before a byte is taken
  assign credit     = {1'b0, q_stat_i.count} + (fsms_pkg::QCNT_W+1)'(s1_valid_q & s1_last_q);
  assign in_ready_o = (credit < (fsms_pkg::QCNT_W+1)'(fsms_pkg::QDEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign count_inc = (count_q < PosSat) ? count_q + 9'd1 : count_q;
  assign alen      = (query_len_i > MaxQuery) ? MaxQuery : query_len_i;
  assign c         = fsms_pkg::fold(in_data_i.text_byte);
  assign search_en = accept && (count_q < LenLimit);
  assign last_idx  = fsms_pkg::QIDX_W'(alen - 5'd1);

  // prefix start chain: a run of hits carries the start forward
  always_comb begin
    new_valid = valid_q;
    upd       = '0;
    for (int k = 0; k < fsms_pkg::MAX_QUERY; k++) begin
      new_start[k] = start_q[k];
      hit[k] = search_en && (c != 8'd0) && (5'(k) < alen) &&
               (c == fsms_pkg::fold(query_chars_i[8*k +: 8]));
    end
    for (int k = 0; k < fsms_pkg::MAX_QUERY; k++) begin
      if (hit[k]) begin
        if (k == 0) begin
          new_start[k] = count_q[7:0];
          new_valid[k] = 1'b1;
          upd[k]       = 1'b1;
        end else if (new_valid[k-1]) begin
          new_start[k] = new_start[k-1];
          new_valid[k] = 1'b1;
          upd[k]       = 1'b1;
        end
      end
    end
    done = (alen != 5'd0) && upd[last_idx];
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
      s1_done_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        count_q    <= in_data_i.last_of_candidate ? '0 : count_inc;
        valid_q    <= in_data_i.last_of_candidate ? '0 : new_valid;
        s1_done_q  <= done;
        s1_last_q  <= in_data_i.last_of_candidate;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < fsms_pkg::MAX_QUERY; k++) begin
        start_q[k] <= new_start[k];
      end
      s1_pos_q   <= count_q[7:0];
      s1_start_q <= new_start[last_idx];
      s1_count_q <= count_inc;
      s1_qlen_q  <= alen;
    end
  end

  // shortest window, first one kept on a tie
  always_comb begin
    span      = s1_pos_q - s1_start_q;
    best_span = best_end_q - best_start_q;
    take_new  = s1_valid_q && s1_done_q && (!best_valid_q || (span < best_span));
    nb_valid  = best_valid_q || take_new;
    nb_start  = take_new ? s1_start_q : best_start_q;
    nb_end    = take_new ? s1_pos_q : best_end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      best_start_q <= '0;
      best_end_q   <= '0;
    end else if (push_o) begin
      best_valid_q <= 1'b0;
      best_start_q <= '0;
      best_end_q   <= '0;
    end else begin
      best_valid_q <= nb_valid;
      best_start_q <= nb_start;
      best_end_q   <= nb_end;
    end
  end

  // candidate summary on the marked byte
  assign push_o                 = s1_valid_q && s1_last_q;
  assign push_data_o.best_valid = nb_valid;
  assign push_data_o.start      = nb_start;
  assign push_data_o.stop       = nb_end;
  assign push_data_o.count      = s1_count_q;
  assign push_data_o.qlen       = s1_qlen_q;

endmodule

FILE: sv/fsms_back.sv
module fsms_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsms_pkg::q_stat_t q_stat_i,
  input  fsms_pkg::summ_t   pop_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fsms_pkg::out_t    out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam logic [8:0] LenLimit = 9'(fsms_pkg::LEN_LIMIT);
  localparam logic [8:0] MaxOut   = 9'd256;
  localparam logic [4:0] LastStep = 5'(fsms_pkg::SCORE_W - 1);

  state_e     state_q;
  logic       matched_q, too_long_q;
  logic [7:0] start_q, end_q;
  logic [8:0] count_q;
  logic [fsms_pkg::DEN_W-1:0]   den_q;
  logic [fsms_pkg::DEN_W:0]     rem_q;
  logic [fsms_pkg::SCORE_W-1:0] num_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  fsms_pkg::out_t out_q;

  logic       too_long, matched, load_out;
  logic [7:0] span;
  logic [fsms_pkg::DEN_W:0] trial;
  logic       fits;

  assign pop_o    = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign too_long = pop_data_i.count > LenLimit;
  assign matched  = pop_data_i.best_valid && !too_long;
  assign span     = end_q - start_q;
  assign trial    = {rem_q[fsms_pkg::DEN_W-1:0], num_q[fsms_pkg::SCORE_W-1]};
  assign fits     = trial >= {1'b0, den_q};
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // score sequencer: multiply span by length, then one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (matched && (pop_data_i.start != pop_data_i.stop)) begin
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_MUL: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == LastStep) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          matched_q  <= matched;
          too_long_q <= too_long;
          start_q    <= matched ? pop_data_i.start : 8'd0;
          end_q      <= matched ? pop_data_i.stop : 8'd0;
          count_q    <= (pop_data_i.count > MaxOut) ? MaxOut : pop_data_i.count;
          num_q      <= !matched ? '0 :
                        (pop_data_i.start == pop_data_i.stop) ?
                        fsms_pkg::SCORE_W'(fsms_pkg::SCORE_SAT) :
                        {pop_data_i.qlen, {fsms_pkg::FRAC_W{1'b0}}};
          den_q      <= fsms_pkg::DEN_W'(pop_data_i.count);
        end
      end
      ST_MUL: begin
        den_q <= fsms_pkg::DEN_W'(span * den_q[8:0]);
        rem_q <= '0;
      end
      ST_DIV: begin
        rem_q <= fits ? trial - {1'b0, den_q} : trial;
        num_q <= {num_q[fsms_pkg::SCORE_W-2:0], fits};
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_q.matched          <= matched_q;
      out_q.window_start     <= start_q;
      out_q.window_end       <= end_q;
      out_q.candidate_length <= count_q;
      out_q.match_score      <= num_q;
      out_q.too_long         <= too_long_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: verif/tb_fuzzy_subsequence_match_scorer.sv
module tb_fuzzy_subsequence_match_scorer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 610;

  // dut connections
  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  fsms_pkg::in_t   in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  fsms_pkg::out_t  out_data;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = fsms_pkg::REG_QUERY_LOW;
  logic [63:0]     cfg_data  = '0;

  // stimulus and scoreboard storage
  fsms_pkg::in_t  text_q[$];
  fsms_pkg::out_t scores_due[$];

  int unsigned bytes_sent    = 0;
  int unsigned bytes_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned matches_seen  = 0;
  int unsigned overlong_seen = 0;
  int unsigned reg_writes    = 0;
  int unsigned errors        = 0;
  int unsigned hold_off      = 0;
  int unsigned stall         = 0;
  int unsigned stuck_cycles  = 0;
  bit          steady        = 1'b0;

  // shadow of the query registers
  logic [63:0] q_low_m  = '0;
  logic [63:0] q_high_m = '0;
  logic [4:0]  q_len_m  = 5'd1;

  // shadow of the per-candidate search state
  logic [8:0]  pre_start [16] = '{default: '0};
  bit          pre_ok    [16] = '{default: 1'b0};
  int unsigned seen  = 0;
  int unsigned win_s = 0;
  int unsigned win_e = 0;
  bit          win_ok = 1'b0;

  fuzzy_subsequence_match_scorer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ascii capitals map to lower case, nothing else changes
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic int unsigned live_len();
    return (q_len_m > 5'd16) ? 16 : int'(q_len_m);
  endfunction

  function automatic logic [7:0] query_at(input int k);
    logic [63:0] w;
    w = (k < 8) ? q_low_m : q_high_m;
    return w[8*(k%8) +: 8];
  endfunction

  function automatic bit work_left();
    return (bytes_taken != bytes_sent) || (scores_due.size() != 0);
  endfunction

  function automatic int unsigned next_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic clear_candidate();
    for (int k = 0; k < 16; k++) begin
      pre_start[k] = '0;
      pre_ok[k]    = 1'b0;
    end
    seen   = 0;
    win_s  = 0;
    win_e  = 0;
    win_ok = 1'b0;
  endtask

  // update latest start per query prefix, keep the shortest leftmost window
  task automatic track_prefixes(input int unsigned pos, input logic [7:0] b);
    int unsigned n;
    int unsigned span;
    logic [7:0]  c;
    bit          done;
    n    = live_len();
    c    = to_lower(b);
    done = 1'b0;
    for (int k = 0; k < int'(n); k++) begin
      if (c != 8'h00 && c == to_lower(query_at(k))) begin
        if (k == 0) begin
          pre_start[0] = 9'(pos);
          pre_ok[0]    = 1'b1;
          done         = done | (n == 1);
        end else if (pre_ok[k-1]) begin
          pre_start[k] = pre_start[k-1];
          pre_ok[k]    = 1'b1;
          done         = done | (k == int'(n) - 1);
        end
      end
    end
    if (done) begin
      span = pos - pre_start[n-1];
      if (!win_ok || span < win_e - win_s) begin
        win_s  = pre_start[n-1];
        win_e  = pos;
        win_ok = 1'b1;
      end
    end
  endtask

  // one accepted byte; the marked byte queues the expected score
  task automatic advance_candidate(input fsms_pkg::in_t t);
    int unsigned       pos;
    bit                over;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   quot;
    fsms_pkg::out_t    r;
    pos = seen;
    if (seen < fsms_pkg::POS_SAT) begin
      seen++;
    end
    if (pos < fsms_pkg::LEN_LIMIT) begin
      track_prefixes(pos, t.text_byte);
    end
    if (t.last_of_candidate) begin
      over = seen > fsms_pkg::LEN_LIMIT;
      r    = '0;
      if (win_ok && !over) begin
        r.matched      = 1'b1;
        r.window_start = 8'(win_s);
        r.window_end   = 8'(win_e);
        if (win_e == win_s) begin
          r.match_score = fsms_pkg::SCORE_W'(fsms_pkg::SCORE_SAT);
        end else begin
          num  = live_len();
          num  = num << fsms_pkg::FRAC_W;
          den  = win_e - win_s;
          den  = den * seen;
          quot = num / den;
          r.match_score = (quot > fsms_pkg::SCORE_SAT) ?
                          fsms_pkg::SCORE_W'(fsms_pkg::SCORE_SAT) :
                          fsms_pkg::SCORE_W'(quot);
        end
      end
      r.candidate_length = (seen > 256) ? 9'd256 : 9'(seen);
      r.too_long         = over;
      scores_due.push_back(r);
      clear_candidate();
    end
  endtask

  task automatic flag_error(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    if (got_v !== want_v) begin
      flag_error($sformatf("result %0d %s: got %0d, want %0d", results_seen, name, got_v,
                           want_v));
    end
  endtask

  task automatic check_score(input fsms_pkg::out_t got);
    fsms_pkg::out_t want;
    results_seen++;
    if (scores_due.size() == 0) begin
      flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = scores_due.pop_front();
      matches_seen  += want.matched;
      overlong_seen += want.too_long;
      compare_field("matched", got.matched, want.matched);
      compare_field("window_start", got.window_start, want.window_start);
      compare_field("window_end", got.window_end, want.window_end);
      compare_field("candidate_length", got.candidate_length, want.candidate_length);
      compare_field("match_score", got.match_score, want.match_score);
      compare_field("too_long", got.too_long, want.too_long);
    end
  endtask

  // input driver, predicts on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_candidate(in_data);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (hold_off != 0) begin
          hold_off--;
          in_valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          in_data  <= text_q.pop_front();
          in_valid <= 1'b1;
          hold_off = next_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure after each transaction outside steady phases
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_score(out_data);
        stall = next_gap();
      end
      if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !work_left()) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d idle cycles, %0d of %0d bytes taken, %0d results owed",
                 stuck_cycles, bytes_taken, bytes_sent, scores_due.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // wait until every byte is taken and every expected result checked, then stay quiet
  task automatic settle();
    do begin
      @(posedge clk);
    end while (work_left());
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      fsms_pkg::REG_QUERY_LOW: begin
        q_low_m = val;
      end
      fsms_pkg::REG_QUERY_HIGH: begin
        q_high_m = val;
      end
      fsms_pkg::REG_QUERY_LEN: begin
        q_len_m = val[4:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_query(input logic [127:0] chars, input logic [63:0] len_word);
    write_reg(fsms_pkg::REG_QUERY_LOW, chars[63:0]);
    write_reg(fsms_pkg::REG_QUERY_HIGH, chars[127:64]);
    write_reg(fsms_pkg::REG_QUERY_LEN, len_word);
  endtask

  // character k of the string lands in byte k
  function automatic logic [127:0] pack_text(input string s);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 16; i++) begin
      r[8*i +: 8] = s[i];
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit last);
    fsms_pkg::in_t t;
    t.text_byte         = b;
    t.last_of_candidate = last;
    text_q.push_back(t);
    bytes_sent++;
  endtask

  task automatic push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], close && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] lc;
    lc = to_lower(c);
    if (lc >= 8'h61 && lc <= 8'h7a && $urandom_range(0, 1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // mostly a small alphabet so that queries hit often
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return flip_case(8'h61 + 8'($urandom_range(0, 3)));
    end
    if (r < 85) begin
      return flip_case(8'h61 + 8'($urandom_range(0, 25)));
    end
    if (r < 97) begin
      return 8'($urandom_range(1, 255));
    end
    return 8'h00;
  endfunction

  function automatic int unsigned filler_count();
    return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 3);
  endfunction

  // query embedded in filler, sometimes with one character dropped, or pure noise
  task automatic add_candidate(input bit close);
    logic [7:0]  txt[$];
    int unsigned n;
    int unsigned kind;
    int unsigned drop;
    n    = live_len();
    kind = $urandom_range(0, 9);
    if (kind < 8 && n != 0) begin
      drop = (kind == 7) ? $urandom_range(0, n - 1) : n;
      repeat (filler_count()) txt.push_back(pick_char());
      for (int k = 0; k < int'(n); k++) begin
        repeat (filler_count()) txt.push_back(pick_char());
        if (k != int'(drop)) begin
          txt.push_back(flip_case(query_at(k)));
        end
      end
      repeat (filler_count()) txt.push_back(pick_char());
    end else begin
      repeat ($urandom_range(1, 12)) txt.push_back(pick_char());
    end
    if (txt.size() == 0) begin
      txt.push_back(pick_char());
    end
    foreach (txt[i]) begin
      push_byte(txt[i], close && i == txt.size() - 1);
    end
  endtask

  task automatic random_query();
    logic [127:0] chars;
    logic [63:0]  len_word;
    int unsigned  r;
    for (int k = 0; k < 16; k++) begin
      chars[8*k +: 8] = pick_char();
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      len_word = $urandom_range(1, 5);
    end else if (r < 88) begin
      len_word = $urandom_range(6, 16);
    end else if (r < 95) begin
      len_word = $urandom_range(17, 31);
    end else begin
      len_word = 0;
    end
    // bits above the length field are ignored
    if ($urandom_range(0, 3) == 0) begin
      len_word[63:5] = 59'({$urandom, $urandom});
    end
    set_query(chars, len_word);
  endtask

  // main sequence
  initial begin
    int unsigned rand_goal;
    int unsigned phase_end;
    int unsigned ph;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset query is a single zero byte: zero text never matches
    push_byte(8'h00, 1'b1);
    push_text("x", 1'b1);

    // case folding, shortest window, leftmost tie
    set_query(pack_text("AB"), 2);
    push_text("aXaB", 1'b1);
    push_text("abab", 1'b1);

    // oversized length clamps to 16; one position satisfies every prefix
    set_query(pack_text("aaaaaaaaaaaaaaaa"), 31);
    push_text("A", 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h80, 1'b1);

    // all-ones query, zero span gives a saturated score
    set_query({16{8'hff}}, 16);
    push_byte(8'hff, 1'b1);

    // zero byte inside the query blocks the match: a, b, 0, d
    set_query(128'h64006261, 4);
    push_text("abd", 1'b1);

    // zero length matches nothing
    write_reg(fsms_pkg::REG_QUERY_LEN, 0);
    push_text("aa", 1'b1);

    // query change inside a candidate keeps the prefix entries
    set_query(pack_text("ab"), 2);
    push_text("xa", 1'b0);
    write_reg(fsms_pkg::REG_QUERY_LOW, 64'h6361); // a, c
    push_text("c", 1'b1);

    // length limit: match ending at the last searched position, then one byte over
    set_query(pack_text("pq"), 2);
    repeat (254) push_byte(8'h78 + 8'($urandom_range(0, 2)), 1'b0);
    push_text("pq", 1'b1);
    repeat (254) push_byte(8'h78 + 8'($urandom_range(0, 2)), 1'b0);
    push_text("PQx", 1'b1);

    // random phases, each with its own query
    rand_goal = bytes_sent + RANDOM_BYTES;
    ph = 0;
    while (bytes_sent < rand_goal) begin
      random_query();
      steady = (ph % 4 == 3);
      phase_end = bytes_sent + $urandom_range(25, 60);
      while (bytes_sent < phase_end) begin
        add_candidate(1'b1);
      end
      // leave a candidate open across the next query change
      if ($urandom_range(0, 3) == 0) begin
        add_candidate(1'b0);
      end
      ph++;
    end
    push_byte(pick_char(), 1'b1);
    settle();

    $display("covered %0d bytes in %0d candidates across %0d register writes",
             bytes_taken, results_seen, reg_writes);
    $display("%0d candidates matched, %0d overlong, %0d mismatches",
             matches_seen, overlong_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
